// ----- design/lpht_pkg.sv -----
// Shared constants and types for the linear-probing hash table.
package lpht_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int KEY_BYTES_DEF = 8;

    localparam int LEN_W     = 5;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int MARK_W    = 2;

    localparam logic [LEN_W-1:0] TLEN_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

endpackage

// ----- design/lpht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/linear_probe_hash_table.sv -----
// Top level of the hash table with open addressing and linear probing.
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/tready         tuser: op; tdata: key, value
//   m_axis    out        m_axis_tvalid/tready         tuser: status; tdata: value_out
//   cfg       in         i_cfg_we                     i_cfg_wdata: table_length
//
// After reset a clearing pass marks all SLOTS slots empty. A request's KEY_BYTES key
// bytes are summed (the byte sum is SUM_W bits wide, 11 for eight bytes), the sum is
// reduced modulo the used length (table_length held to 1..SLOTS) and 1 to that many
// probes follow, then a write on a successful insert or remove; an unused op goes to output.
// One shared adder serves byte sum, remainder and slot advance; each probe is one read.
// A result waits in the output register; a request finishing before it drains waits too.
module linear_probe_hash_table #(
    parameter int SLOTS     = lpht_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = lpht_pkg::KEY_BYTES_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // Fields from bit 0: key (64), value (64).
    input  logic [lpht_pkg::KEY_W+lpht_pkg::VALUE_W-1:0]    s_axis_tdata,
    // Fields from bit 0: op (2).
    input  logic [lpht_pkg::OP_W-1:0]                       s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // Fields from bit 0: value_out (64).
    output logic [lpht_pkg::VALUE_W-1:0]                    m_axis_tdata,
    // Fields from bit 0: status (2).
    output logic [lpht_pkg::STATUS_W-1:0]                   m_axis_tuser,
    input  logic                                            i_cfg_we,
    input  logic [lpht_pkg::LEN_W-1:0]                      i_cfg_wdata
);

    localparam int IW    = $clog2(SLOTS);
    localparam int KW    = 8 * KEY_BYTES;
    localparam int VW    = lpht_pkg::VALUE_W;
    localparam int LW    = lpht_pkg::LEN_W;
    localparam int SW    = $clog2(255 * KEY_BYTES + 1);
    localparam int MAXW0 = (SW > IW) ? SW : IW;
    localparam int MAXW1 = (MAXW0 > LW + 1) ? MAXW0 : LW + 1;
    localparam int AW    = MAXW1 + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_MOD   = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_WRITE = 8'b0010_0000,
        S_OUT   = 8'b0100_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [LW-1:0]            r_tlen;
    logic [IW-1:0]            r_clr, n_clr;
    logic [lpht_pkg::OP_W-1:0] r_op, n_op;
    logic [KW-1:0]            r_key, n_key;
    logic [KW-1:0]            r_ksh, n_ksh;
    logic [VW-1:0]            r_value, n_value;
    logic [LW-1:0]            r_n, n_n;
    logic [LW-1:0]            r_cnt, n_cnt;
    logic [SW-1:0]            r_acc, n_acc;
    logic [LW-1:0]            r_rem, n_rem;
    logic [IW-1:0]            r_h, n_h;
    logic                     r_free_v, n_free_v;
    logic [IW-1:0]            r_waddr, n_waddr;
    lpht_pkg::t_mark          r_wmark, n_wmark;
    lpht_pkg::t_status        r_res_st, n_res_st;
    logic [VW-1:0]            r_res_val, n_res_val;
    logic                     r_out_valid, n_out_valid;
    lpht_pkg::t_status        r_out_st, n_out_st;
    logic [VW-1:0]            r_out_val, n_out_val;

    logic [LW-1:0]            len_use;
    logic [AW-1:0]            alu_a, alu_b, alu_y;
    logic                     alu_sub;
    logic [IW-1:0]            h_next;
    logic [lpht_pkg::MARK_W-1:0] rd_mark;
    logic [KW+VW-1:0]         rd_kv;
    logic                     kv_we, mk_we;
    logic [IW-1:0]            mk_waddr;
    logic [lpht_pkg::MARK_W-1:0] mk_wdata;
    logic                     in_acc;
    logic                     is_empty, is_match, last_probe;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        if (r_tlen == '0) begin
            len_use = LW'(1);
        end else if (32'(r_tlen) > 32'(SLOTS)) begin
            len_use = LW'(SLOTS);
        end else begin
            len_use = r_tlen;
        end
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_SUM: begin
                alu_a = AW'(r_acc);
                alu_b = AW'(r_ksh[7:0]);
            end
            S_MOD: begin
                alu_a   = AW'({r_rem, r_acc[SW-1]});
                alu_b   = AW'(r_n);
                alu_sub = 1'b1;
            end
            S_CHECK: begin
                alu_a = AW'(r_h);
                alu_b = AW'(1);
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign h_next = (alu_y == AW'(r_n)) ? '0 : alu_y[IW-1:0];

    assign is_empty   = (rd_mark == lpht_pkg::MARK_EMPTY);
    assign is_match   = (rd_mark == lpht_pkg::MARK_USED) && (rd_kv[KW-1:0] == r_key);
    assign last_probe = ((r_cnt + LW'(1)) == r_n);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_key       = r_key;
        n_ksh       = r_ksh;
        n_value     = r_value;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_h         = r_h;
        n_free_v    = r_free_v;
        n_waddr     = r_waddr;
        n_wmark     = r_wmark;
        n_res_st    = r_res_st;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_st    = r_out_st;
        n_out_val   = r_out_val;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = s_axis_tuser;
                    n_key     = s_axis_tdata[KW-1:0];
                    n_ksh     = s_axis_tdata[KW-1:0];
                    n_value   = s_axis_tdata[lpht_pkg::KEY_W +: VW];
                    n_n       = len_use;
                    n_cnt     = '0;
                    n_acc     = '0;
                    n_rem     = '0;
                    n_free_v  = 1'b0;
                    n_res_st  = lpht_pkg::ST_NOT_FOUND;
                    n_res_val = '0;
                    if (s_axis_tuser inside {lpht_pkg::OP_INSERT, lpht_pkg::OP_FIND,
                                             lpht_pkg::OP_REMOVE}) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SUM: begin
                n_acc = alu_y[SW-1:0];
                n_ksh = r_ksh >> 8;
                n_cnt = r_cnt + LW'(1);
                if (r_cnt == LW'(KEY_BYTES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_acc = r_acc << 1;
                if (alu_y[AW-1]) begin
                    n_rem = {r_rem[LW-2:0], r_acc[SW-1]};
                end else begin
                    n_rem = alu_y[LW-1:0];
                end
                n_cnt = r_cnt + LW'(1);
                if (r_cnt == LW'(SW - 1)) begin
                    n_cnt   = '0;
                    n_h     = IW'(n_rem);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_free_v && !is_match && (rd_mark != lpht_pkg::MARK_USED)) begin
                    n_free_v = 1'b1;
                    n_waddr  = r_h;
                end
                if (is_empty || is_match || last_probe) begin
                    n_state = S_OUT;
                    case (r_op)
                        lpht_pkg::OP_INSERT: begin
                            if (is_match) begin
                                n_res_st = lpht_pkg::ST_DUPLICATE;
                            end else if (n_free_v) begin
                                n_res_st = lpht_pkg::ST_DONE;
                                n_wmark  = lpht_pkg::MARK_USED;
                                n_state  = S_WRITE;
                            end else begin
                                n_res_st = lpht_pkg::ST_FULL;
                            end
                        end
                        lpht_pkg::OP_FIND: begin
                            if (is_match) begin
                                n_res_st  = lpht_pkg::ST_DONE;
                                n_res_val = rd_kv[KW +: VW];
                            end
                        end
                        lpht_pkg::OP_REMOVE: begin
                            if (is_match) begin
                                n_res_st = lpht_pkg::ST_DONE;
                                n_waddr  = r_h;
                                n_wmark  = lpht_pkg::MARK_DELETED;
                                n_state  = S_WRITE;
                            end
                        end
                        default: begin
                            n_res_st = lpht_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end else begin
                    n_h   = h_next;
                    n_cnt = r_cnt + LW'(1);
                end
            end
            S_WRITE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_val   = r_res_val;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_tlen      <= lpht_pkg::TLEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tlen <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_ksh     <= n_ksh;
        r_value   <= n_value;
        r_n       <= n_n;
        r_cnt     <= n_cnt;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_h       <= n_h;
        r_free_v  <= n_free_v;
        r_waddr   <= n_waddr;
        r_wmark   <= n_wmark;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
    end

    assign kv_we    = (r_state == S_WRITE) && (r_wmark == lpht_pkg::MARK_USED);
    assign mk_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign mk_waddr = (r_state == S_CLEAR) ? r_clr : r_waddr;
    assign mk_wdata = (r_state == S_CLEAR) ? lpht_pkg::MARK_EMPTY : r_wmark;

    lpht_ram #(
        .WIDTH (KW + VW),
        .DEPTH (SLOTS)
    ) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (r_waddr),
        .i_wdata ({r_value, r_key}),
        .i_raddr (n_h),
        .o_rdata (rd_kv)
    );

    lpht_ram #(
        .WIDTH (lpht_pkg::MARK_W),
        .DEPTH (SLOTS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_waddr),
        .i_wdata (mk_wdata),
        .i_raddr (n_h),
        .o_rdata (rd_mark)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = r_out_val;

endmodule

// ----- design/lpht_check.sv -----
// Port-level checker for the hash table, bound to the top level.
module lpht_check (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         s_axis_tvalid,
    input  logic                                         s_axis_tready,
    input  logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    input  logic [lpht_pkg::VALUE_W-1:0]                 m_axis_tdata,
    input  logic [lpht_pkg::STATUS_W-1:0]                m_axis_tuser
);

    // A stalled result must hold its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // Only a successful find carries a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != lpht_pkg::ST_DONE) |-> m_axis_tdata == '0)
        else $error("nonzero value on an unsuccessful result");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind linear_probe_hash_table lpht_check u_lpht_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the linear-probing hash table with its own table predictor.
module tb_top;

    localparam logic [lpht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 38;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE = lpht_pkg::SLOTS_DEF + 4;

    typedef struct packed {
        logic [lpht_pkg::OP_W-1:0]    op;
        logic [lpht_pkg::KEY_W-1:0]   key;
        logic [lpht_pkg::VALUE_W-1:0] value;
    } t_table_req;

    typedef struct packed {
        lpht_pkg::t_status            status;
        logic [lpht_pkg::VALUE_W-1:0] value;
    } t_table_resp;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // Fields from bit 0: key (64), value (64).
    logic [lpht_pkg::KEY_W+lpht_pkg::VALUE_W-1:0] s_axis_tdata = '0;
    // Fields from bit 0: op (2).
    logic [lpht_pkg::OP_W-1:0]      s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // Fields from bit 0: value_out (64).
    logic [lpht_pkg::VALUE_W-1:0]   m_axis_tdata;
    // Fields from bit 0: status (2).
    logic [lpht_pkg::STATUS_W-1:0]  m_axis_tuser;
    logic                           i_cfg_we = 1'b0;
    logic [lpht_pkg::LEN_W-1:0]     i_cfg_wdata = '0;

    t_table_req     pending_reqs[$];
    t_table_resp    expected_resps[$];
    t_table_req     bus_req;
    logic [lpht_pkg::KEY_W-1:0]   slot_key [lpht_pkg::SLOTS_DEF];
    logic [lpht_pkg::VALUE_W-1:0] slot_value [lpht_pkg::SLOTS_DEF];
    lpht_pkg::t_mark              slot_mark [lpht_pkg::SLOTS_DEF];
    logic [lpht_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];
    int table_len = lpht_pkg::SLOTS_DEF;
    int status_tally [4] = '{0, 0, 0, 0};
    int phase_lens [10] = '{2, 16, 5, 31, 1, 9, 0, 17, 3, 16};
    int sent_count = 0;
    int resp_count = 0;
    int error_count = 0;
    int cfg_writes = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic calm;

    linear_probe_hash_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int s = 0; s < lpht_pkg::SLOTS_DEF; s++) begin
            slot_mark[s] = lpht_pkg::MARK_EMPTY;
        end
    end

    assign calm = (sent_count >= 450) && (sent_count < 600);

    function automatic int used_length();
        return (table_len < 1) ? 1 :
               (table_len > lpht_pkg::SLOTS_DEF) ? lpht_pkg::SLOTS_DEF : table_len;
    endfunction

    function automatic t_table_resp hash_table_apply(t_table_req req);
        t_table_resp resp;
        int n;
        int sum;
        int h;
        int free_at;
        int hit_at;
        resp.status = lpht_pkg::ST_NOT_FOUND;
        resp.value = '0;
        n = used_length();
        sum = 0;
        for (int b = 0; b < lpht_pkg::KEY_BYTES_DEF; b++) begin
            sum += req.key[8*b +: 8];
        end
        h = sum % n;
        free_at = -1;
        hit_at = -1;
        for (int c = 0; c < n; c++) begin
            if (slot_mark[h] == lpht_pkg::MARK_EMPTY) begin
                if (free_at < 0) free_at = h;
                break;
            end
            if (slot_mark[h] == lpht_pkg::MARK_DELETED) begin
                if (free_at < 0) free_at = h;
            end else if (slot_key[h] == req.key) begin
                hit_at = h;
                break;
            end
            h = (h + 1) % n;
        end
        case (req.op)
            lpht_pkg::OP_INSERT: begin
                if (hit_at >= 0) begin
                    resp.status = lpht_pkg::ST_DUPLICATE;
                end else if (free_at >= 0) begin
                    slot_key[free_at] = req.key;
                    slot_value[free_at] = req.value;
                    slot_mark[free_at] = lpht_pkg::MARK_USED;
                    resp.status = lpht_pkg::ST_DONE;
                end else begin
                    resp.status = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::OP_FIND: begin
                if (hit_at >= 0) begin
                    resp.status = lpht_pkg::ST_DONE;
                    resp.value = slot_value[hit_at];
                end
            end
            lpht_pkg::OP_REMOVE: begin
                if (hit_at >= 0) begin
                    slot_mark[hit_at] = lpht_pkg::MARK_DELETED;
                    resp.status = lpht_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
        status_tally[resp.status]++;
        return resp;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < 50) $display("MISMATCH at response %0d: %s", resp_count, what);
        error_count++;
    endtask

    task automatic queue_request(logic [lpht_pkg::OP_W-1:0] op,
                                 logic [lpht_pkg::KEY_W-1:0] key,
                                 logic [lpht_pkg::VALUE_W-1:0] value);
        t_table_req req;
        req.op = op;
        req.key = key;
        req.value = value;
        pending_reqs.push_back(req);
    endtask

    task automatic queue_random_request(int pool_n);
        int r;
        logic [lpht_pkg::OP_W-1:0] op;
        logic [lpht_pkg::KEY_W-1:0] key;
        r = $urandom_range(99);
        key = key_pool[$urandom_range(pool_n - 1)];
        if (r < 5) begin
            op = (lpht_pkg::OP_W)'($urandom_range(3));
            key = {$urandom, $urandom};
        end else if (r < 45) begin
            op = lpht_pkg::OP_INSERT;
        end else if (r < 78) begin
            op = lpht_pkg::OP_FIND;
        end else begin
            op = lpht_pkg::OP_REMOVE;
        end
        queue_request(op, key, {$urandom, $urandom});
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_table_length(int len);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= (lpht_pkg::LEN_W)'(len);
        table_len = len;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resps.push_back(hash_table_apply(bus_req));
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    bus_req = pending_reqs.pop_front();
                    s_axis_tdata <= {bus_req.value, bus_req.key};
                    s_axis_tuser <= bus_req.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && resp_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_table_resp exp_resp;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    exp_resp = expected_resps.pop_front();
                    if (m_axis_tuser !== exp_resp.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, exp_resp.status));
                    end
                    if (m_axis_tdata !== exp_resp.value) begin
                        report_mismatch($sformatf("value_out %h, expected %h",
                                                  m_axis_tdata, exp_resp.value));
                    end
                end
                resp_count++;
            end
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        #5000000;
        $display("Timeout with %0d responses outstanding.", expected_resps.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = (i % 3 == 0) ? (lpht_pkg::KEY_W)'($urandom_range(255))
                                       : {$urandom, $urandom};
        end

        set_table_length(lpht_pkg::SLOTS_DEF);
        queue_request(lpht_pkg::OP_FIND, 64'h0000_0000_0000_0042, '0);
        queue_request(lpht_pkg::OP_REMOVE, 64'h0000_0000_0000_0042, '0);
        queue_request(lpht_pkg::OP_INSERT, 64'h0, '1);
        queue_request(lpht_pkg::OP_FIND, 64'h0, '0);
        queue_request(lpht_pkg::OP_INSERT, '1, '0);
        queue_request(lpht_pkg::OP_INSERT, 64'h0, 64'h1234);
        queue_request(lpht_pkg::OP_INSERT, 64'h01, {$urandom, $urandom});
        queue_request(lpht_pkg::OP_INSERT, 64'h0100, {$urandom, $urandom});
        queue_request(lpht_pkg::OP_INSERT, 64'h010000, {$urandom, $urandom});
        queue_request(lpht_pkg::OP_REMOVE, 64'h0100, '0);
        queue_request(lpht_pkg::OP_FIND, 64'h010000, '0);
        queue_request(lpht_pkg::OP_INSERT, 64'h010000, '1);
        queue_request(lpht_pkg::OP_INSERT, 64'h0100, {$urandom, $urandom});
        queue_request(OP_UNUSED, '1, '1);
        queue_request(lpht_pkg::OP_FIND, '1, '1);
        queue_request(lpht_pkg::OP_REMOVE, '1, '0);
        queue_request(lpht_pkg::OP_FIND, '1, '0);

        set_table_length(1);
        queue_request(lpht_pkg::OP_REMOVE, 64'h0, '0);
        queue_request(lpht_pkg::OP_INSERT, 64'h55, {$urandom, $urandom});
        queue_request(lpht_pkg::OP_INSERT, 64'h66, {$urandom, $urandom});
        queue_request(lpht_pkg::OP_INSERT, 64'h55, {$urandom, $urandom});

        set_table_length(0);
        queue_request(lpht_pkg::OP_FIND, 64'h55, '0);
        queue_request(lpht_pkg::OP_REMOVE, 64'h55, '0);
        queue_request(lpht_pkg::OP_INSERT, 64'h66, {$urandom, $urandom});

        foreach (phase_lens[p]) begin
            set_table_length(phase_lens[p]);
            repeat (78) queue_random_request(used_length() + 4);
        end

        wait_until_idle();
        repeat (60) @(posedge i_clk);
        $display("Ran %0d requests over %0d table length settings, with one long output stall.",
                 sent_count, cfg_writes);
        $display("Outcomes: %0d done or found, %0d not found, %0d duplicates, %0d full.",
                 status_tally[lpht_pkg::ST_DONE], status_tally[lpht_pkg::ST_NOT_FOUND],
                 status_tally[lpht_pkg::ST_DUPLICATE], status_tally[lpht_pkg::ST_FULL]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches.", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
